### src/sweep_coverage_intervals_macros.svh
// assertion macros shared by the sweep coverage rtl
`ifndef SWEEP_COVERAGE_INTERVALS_MACROS_SVH
`define SWEEP_COVERAGE_INTERVALS_MACROS_SVH

// clocked check, disabled while reset is asserted (active-low reset)
`define SCI_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// clocked check that also holds during reset
`define SCI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/sci_pkg.sv
// shared types and constants for the sweep line coverage block
`default_nettype none

package sci_pkg;

    localparam int AXIS_W       = 32;
    localparam int POS_W        = 32;
    localparam int SEG_DEPTH_W  = 16;
    localparam int SUM_W        = 64;
    localparam int MIN_COV_W    = 16;
    localparam int DEPTH_BITS_DEF = 16;

    localparam logic [MIN_COV_W-1:0] MIN_COV_RESET = 16'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OPEN_AXIS = 2'd1,
        ST_NEGATIVE  = 2'd2,
        ST_OVERFLOW  = 2'd3
    } status_t;

endpackage

`default_nettype wire

### src/sweep_coverage_intervals.sv
// sweep line interval coverage: depth tracking, segment report and covered total
// path: a request passes the input register, then the result register; an untaken result holds it at the input
// throughput: one endpoint request per cycle while s_tready is high; the state update is one add/subtract and compares
// s_tready drops only while both the input register and an untaken result are full
// reset (aresetn low, synchronous): both stages empty, min_coverage 2, depth zero,
// last axis and last position all ones, covered total zero
`default_nettype none
`include "sweep_coverage_intervals_macros.svh"

module sweep_coverage_intervals #(
    parameter int DEPTH_BITS = sci_pkg::DEPTH_BITS_DEF
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,

    // configuration: min_coverage
    input  wire logic          cfg_we,
    input  wire logic [15:0]   cfg_wdata,

    // endpoint request channel
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire logic [63:0]   s_tdata,   // [31:0] axis_id, [63:32] event_position
    input  wire logic          s_tuser,   // [0] is_end

    // result channel
    output logic               m_tvalid,
    input  wire logic          m_tready,
    output logic [175:0]       m_tdata,   // [31:0] segment_axis, [63:32] segment_begin,
                                          // [95:64] segment_end, [111:96] segment_depth,
                                          // [175:112] covered_sum
    output logic [2:0]         m_tuser    // [0] segment_valid, [2:1] status
);

    // depth compare width covers both the threshold and the depth counter
    localparam int CMP_W = (DEPTH_BITS > sci_pkg::MIN_COV_W) ? DEPTH_BITS : sci_pkg::MIN_COV_W;

    // ---------------- configuration ----------------
    logic [sci_pkg::MIN_COV_W-1:0] min_cov_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_cov_reg <= sci_pkg::MIN_COV_RESET;
        end else if (cfg_we) begin
            min_cov_reg <= cfg_wdata;
        end
    end

    // ---------------- input register ----------------
    logic                        in_valid_reg;
    logic [sci_pkg::AXIS_W-1:0]  in_axis_reg;
    logic [sci_pkg::POS_W-1:0]   in_pos_reg;
    logic                        in_end_reg;

    logic                        out_valid_reg;
    logic                        advance;

    // the input stage moves on whenever the result register is free or being drained
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_axis_reg <= s_tdata[31:0];
            in_pos_reg  <= s_tdata[63:32];
            in_end_reg  <= s_tuser;
        end
    end

    // ---------------- sweep state ----------------
    logic [sci_pkg::AXIS_W-1:0]  last_axis_reg;
    logic [sci_pkg::POS_W-1:0]   last_pos_reg;
    logic [DEPTH_BITS-1:0]       depth_reg;
    logic [sci_pkg::SUM_W-1:0]   total_reg;

    // ---------------- event evaluation ----------------
    logic                        depth_zero;
    logic                        depth_full;
    logic                        axis_change;
    sci_pkg::status_t            status_next;
    logic                        seg_next;
    logic [CMP_W-1:0]            depth_ext;
    logic [CMP_W-1:0]            min_ext;
    logic [sci_pkg::POS_W-1:0]   seg_len;
    logic [sci_pkg::SUM_W-1:0]   total_sum;
    logic [DEPTH_BITS-1:0]       depth_next;

    assign depth_zero  = (depth_reg == '0);
    assign depth_full  = &depth_reg;
    assign axis_change = (in_axis_reg != last_axis_reg);
    assign depth_ext   = CMP_W'(depth_reg);
    assign min_ext     = CMP_W'(min_cov_reg);

    // axis change with open coverage wins over the depth checks
    always_comb begin
        if (axis_change && !depth_zero) begin
            status_next = sci_pkg::ST_OPEN_AXIS;
        end else if (in_end_reg && depth_zero) begin
            status_next = sci_pkg::ST_NEGATIVE;
        end else if (!in_end_reg && depth_full) begin
            status_next = sci_pkg::ST_OVERFLOW;
        end else begin
            status_next = sci_pkg::ST_OK;
        end
    end

    // zero depth never reports, so a zero threshold behaves like one
    assign seg_next = (status_next == sci_pkg::ST_OK) && !depth_zero &&
                      (depth_ext >= min_ext) && (in_pos_reg > last_pos_reg);

    assign seg_len    = in_pos_reg - last_pos_reg;
    assign total_sum  = total_reg + sci_pkg::SUM_W'(seg_len);
    assign depth_next = in_end_reg ? (depth_reg - 1'b1) : (depth_reg + 1'b1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_axis_reg <= '1;
            last_pos_reg  <= '1;
            depth_reg     <= '0;
            total_reg     <= '0;
        end else if (advance && (status_next == sci_pkg::ST_OK)) begin
            // a flagged event leaves the state untouched
            depth_reg     <= depth_next;
            last_axis_reg <= in_axis_reg;
            last_pos_reg  <= in_pos_reg;
            if (seg_next) begin
                total_reg <= total_sum;
            end
        end
    end

    // ---------------- result register ----------------
    logic                             seg_valid_reg;
    logic [sci_pkg::AXIS_W-1:0]       seg_axis_reg;
    logic [sci_pkg::POS_W-1:0]        seg_begin_reg;
    logic [sci_pkg::POS_W-1:0]        seg_end_reg;
    logic [sci_pkg::SEG_DEPTH_W-1:0]  seg_depth_reg;
    logic [sci_pkg::SUM_W-1:0]        cov_sum_reg;
    sci_pkg::status_t                 status_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            seg_valid_reg <= seg_next;
            // segment fields read zero when nothing is reported
            seg_axis_reg  <= seg_next ? last_axis_reg : '0;
            seg_begin_reg <= seg_next ? last_pos_reg  : '0;
            seg_end_reg   <= seg_next ? in_pos_reg    : '0;
            seg_depth_reg <= seg_next ? depth_ext[sci_pkg::SEG_DEPTH_W-1:0] : '0;
            cov_sum_reg   <= seg_next ? total_sum : total_reg;
            status_reg    <= status_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {cov_sum_reg, seg_depth_reg, seg_end_reg, seg_begin_reg, seg_axis_reg};
    assign m_tuser  = {status_reg, seg_valid_reg};

    // ---------------- assertions ----------------
    `SCI_ASSERT_CLK(a_seg_only_ok, aclk, aresetn,
        (out_valid_reg && seg_valid_reg) |-> (status_reg == sci_pkg::ST_OK),
        "segment reported with an error status")
    `SCI_ASSERT_CLK(a_seg_advances, aclk, aresetn,
        (out_valid_reg && seg_valid_reg) |-> (seg_end_reg > seg_begin_reg),
        "reported segment does not advance")
    `SCI_ASSERT_CLK(a_flagged_keeps_depth, aclk, aresetn,
        (advance && (status_next != sci_pkg::ST_OK)) |=> (depth_reg == $past(depth_reg)),
        "flagged event changed the depth count")
    `SCI_ASSERT_CLK(a_stall_only_when_full, aclk, aresetn,
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready),
        "input stalled while the pipeline can move")

endmodule

`default_nettype wire

### dv/sweep_coverage_intervals_tb.sv
`timescale 1ns / 100ps
// testbench for the sweep line coverage block: request stream, result checks, idling and stalls

module sweep_coverage_intervals_tb;

    localparam int DEPTH_BITS = sci_pkg::DEPTH_BITS_DEF;
    localparam logic [DEPTH_BITS-1:0] DEPTH_FULL = '1;
    // the slowest correct run stays well within this limit, mostly receiver idling
    localparam int CYCLE_LIMIT = 100_000;
    localparam int DRAIN_CYCLES = 8;

    // one result as the block reports it
    typedef struct packed {
        logic                            seg_valid;
        logic [sci_pkg::AXIS_W-1:0]      seg_axis;
        logic [sci_pkg::POS_W-1:0]       seg_begin;
        logic [sci_pkg::POS_W-1:0]       seg_end;
        logic [sci_pkg::SEG_DEPTH_W-1:0] seg_depth;
        logic [sci_pkg::SUM_W-1:0]       sum;
        sci_pkg::status_t                status;
    } coverage_report_t;

    logic          aclk;
    logic          aresetn;
    logic          cfg_we;
    logic [15:0]   cfg_wdata;
    logic          s_tvalid;
    logic          s_tready;
    logic [63:0]   s_tdata;   // [31:0] axis_id, [63:32] event_position
    logic          s_tuser;   // [0] is_end
    logic          m_tvalid;
    logic          m_tready;
    logic [175:0]  m_tdata;   // [31:0] segment_axis, [63:32] segment_begin,
                              // [95:64] segment_end, [111:96] segment_depth,
                              // [175:112] covered_sum
    logic [2:0]    m_tuser;   // [0] segment_valid, [2:1] status

    // sweep state as the block should hold it
    logic [sci_pkg::AXIS_W-1:0]    cov_axis;
    logic [sci_pkg::POS_W-1:0]     cov_pos;
    logic [DEPTH_BITS-1:0]         cov_depth;
    logic [sci_pkg::SUM_W-1:0]     covered_bases;
    logic [sci_pkg::MIN_COV_W-1:0] min_cov;

    // reports still owed by the block, oldest first
    coverage_report_t coverage_reports[$];

    int error_count = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int rx_hold_cycles = 0;

    sweep_coverage_intervals dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // run limit: a hung handshake ends here
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // sweep update for one accepted endpoint request; returns the report it must produce
    function automatic coverage_report_t predict_endpoint(
        input logic [sci_pkg::AXIS_W-1:0] axis,
        input logic [sci_pkg::POS_W-1:0] pos,
        input logic is_end);
        coverage_report_t r;
        logic [sci_pkg::POS_W-1:0] seg_len;
        r = '0;
        r.status = sci_pkg::ST_OK;
        // axis change with open coverage wins over the depth checks
        if (axis != cov_axis && cov_depth != 0)
            r.status = sci_pkg::ST_OPEN_AXIS;
        else if (is_end && cov_depth == 0)
            r.status = sci_pkg::ST_NEGATIVE;
        else if (!is_end && cov_depth == DEPTH_FULL)
            r.status = sci_pkg::ST_OVERFLOW;
        if (r.status == sci_pkg::ST_OK) begin
            // zero depth never reports, so a zero threshold behaves as one
            if (cov_depth != 0 && cov_depth >= min_cov && pos > cov_pos) begin
                seg_len = pos - cov_pos;
                r.seg_valid = 1'b1;
                r.seg_axis = cov_axis;
                r.seg_begin = cov_pos;
                r.seg_end = pos;
                r.seg_depth = 16'(cov_depth);
                covered_bases += seg_len;
            end
            cov_depth = is_end ? cov_depth - 1'b1 : cov_depth + 1'b1;
            cov_axis = axis;
            cov_pos = pos;
        end
        // ignored requests leave the state alone and show the old total
        r.sum = covered_bases;
        return r;
    endfunction

    task automatic compare_field(input string name, input logic [63:0] exp_val,
                                 input logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $error("%s mismatch: expected %0h, got %0h", name, exp_val, act_val);
            error_count++;
        end
    endtask

    task automatic check_report();
        coverage_report_t exp_r;
        if (coverage_reports.size() == 0) begin
            $error("result with no request waiting: tdata %0h tuser %0h", m_tdata, m_tuser);
            error_count++;
        end else begin
            exp_r = coverage_reports.pop_front();
            compare_field("segment_valid", exp_r.seg_valid, m_tuser[0]);
            compare_field("status", exp_r.status, m_tuser[2:1]);
            compare_field("segment_axis", exp_r.seg_axis, m_tdata[31:0]);
            compare_field("segment_begin", exp_r.seg_begin, m_tdata[63:32]);
            compare_field("segment_end", exp_r.seg_end, m_tdata[95:64]);
            compare_field("segment_depth", exp_r.seg_depth, m_tdata[111:96]);
            compare_field("covered_sum", exp_r.sum, m_tdata[175:112]);
        end
    endtask

    // result side: samples at each edge, then picks the next tready
    initial begin
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready)
                check_report();
            // a requested hold-off is counted down here, cycle by cycle
            if (rx_hold_cycles > 0) begin
                rx_hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    // offer one endpoint request, idling at random first, and wait for its acceptance
    task automatic send_endpoint(input logic [sci_pkg::AXIS_W-1:0] axis,
                                 input logic [sci_pkg::POS_W-1:0] pos,
                                 input logic is_end);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {pos, axis};
        s_tuser <= is_end;
        do @(posedge aclk); while (!s_tready);
        coverage_reports.push_back(predict_endpoint(axis, pos, is_end));
    endtask

    // sender goes quiet until every owed report has come back
    task automatic wait_reports();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (coverage_reports.size() != 0);
    endtask

    // threshold is only written with the block idle
    task automatic write_min_coverage(input logic [sci_pkg::MIN_COV_W-1:0] value);
        wait_reports();
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        min_cov = value;
    endtask

    // end every open interval on the current axis
    task automatic close_axis();
        while (cov_depth != 0)
            send_endpoint(cov_axis, cov_pos + $urandom_range(3), 1'b1);
    endtask

    // fixed cases: field extremes, every status but overflow, stalled positions, threshold corners
    task automatic test_directed_cases();
        send_endpoint(32'd5, 32'd10, 1'b1);              // end at zero depth
        send_endpoint(32'd0, 32'd0, 1'b0);               // first begin after reset
        send_endpoint(32'd0, 32'd0, 1'b0);               // position not advanced
        send_endpoint(32'd0, 32'd100, 1'b0);             // segment at depth 2
        send_endpoint(32'd1, 32'd150, 1'b0);             // axis change while open
        send_endpoint(32'd0, 32'd100, 1'b1);             // same position again
        send_endpoint(32'd0, 32'd60, 1'b1);              // position goes backward
        send_endpoint(32'd0, 32'd80, 1'b1);              // depth below threshold
        send_endpoint(32'd0, 32'd90, 1'b1);              // end at zero depth again
        send_endpoint(32'hFFFF_FFFF, 32'd0, 1'b0);
        send_endpoint(32'hFFFF_FFFF, 32'd0, 1'b0);
        send_endpoint(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);  // widest segment
        send_endpoint(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        // zero threshold reports depth one
        write_min_coverage(16'd0);
        send_endpoint(32'hAAAA_5555, 32'd20, 1'b0);
        send_endpoint(32'hAAAA_5555, 32'd30, 1'b1);
        write_min_coverage(16'd1);
        send_endpoint(32'h5555_AAAA, 32'd40, 1'b0);
        send_endpoint(32'h5555_AAAA, 32'd41, 1'b1);
        // top threshold, nothing reported at low depth
        write_min_coverage(16'hFFFF);
        send_endpoint(32'h0F0F_F0F0, 32'd7, 1'b0);
        send_endpoint(32'h0F0F_F0F0, 32'd12, 1'b0);
        send_endpoint(32'h0F0F_F0F0, 32'd20, 1'b1);
        send_endpoint(32'h0F0F_F0F0, 32'd25, 1'b1);
        write_min_coverage(16'd2);
    endtask

    // mostly sorted sweeps with random content, plus noise and broken sequences
    task automatic test_random_sweeps(input int n_items);
        int sent;
        int roll;
        logic [sci_pkg::POS_W-1:0] start_pos;
        logic is_end;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < 8) begin
                // noise: anything at all
                send_endpoint($urandom, $urandom, 1'($urandom_range(1)));
            end else if (roll < 14) begin
                // broken order: jump axis while open, or end with nothing open
                if (cov_depth != 0)
                    send_endpoint(cov_axis ^ (32'h1 << $urandom_range(31)), cov_pos + 1, 1'b0);
                else
                    send_endpoint(cov_axis, cov_pos + 1, 1'b1);
            end else if (cov_depth == 0 && $urandom_range(3) == 0) begin
                // fresh axis, start low, anywhere, or just under the top
                case ($urandom_range(3))
                    0: start_pos = $urandom;
                    1: start_pos = 32'hFFFF_FFC0 + $urandom_range(63);
                    default: start_pos = $urandom_range(5000);
                endcase
                send_endpoint($urandom, start_pos, 1'b0);
            end else begin
                if (cov_depth == 0)
                    is_end = 1'b0;
                else if (cov_depth >= 8)
                    is_end = 1'b1;
                else
                    is_end = ($urandom_range(99) < 45);
                send_endpoint(cov_axis,
                              cov_pos + (($urandom_range(3) == 0) ? 0 : $urandom_range(1, 40)),
                              is_end);
            end
            sent++;
        end
    endtask

    // receiver stops for a long stretch while requests keep coming, so input backs up
    task automatic test_receiver_hold();
        wait_reports();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_cycles = 300;
        test_random_sweeps(40);
        wait_reports();
    endtask

    // nest deeper than the random sweeps reach, with a threshold only deep coverage meets
    task automatic test_deep_nesting();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        close_axis();
        write_min_coverage(16'd16);
        for (int i = 0; i < 24; i++)
            send_endpoint(32'd7, 32'(i * 5), 1'b0);
        close_axis();
        write_min_coverage(16'd2);
    endtask

    initial begin
        aresetn <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= 1'b0;
        cov_axis = '1;
        cov_pos = '1;
        cov_depth = '0;
        covered_bases = '0;
        min_cov = sci_pkg::MIN_COV_RESET;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // sender rarely idle, receiver mostly stalled
        tx_idle_pct = 9;
        rx_idle_pct = 64;
        test_directed_cases();
        write_min_coverage(16'd1);
        test_random_sweeps(120);

        // the other way round
        write_min_coverage(16'd3);
        tx_idle_pct = 64;
        rx_idle_pct = 9;
        test_random_sweeps(120);

        // back to back, no idling
        write_min_coverage(16'($urandom_range(1, 4)));
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        test_random_sweeps(120);

        test_receiver_hold();
        test_deep_nesting();

        wait_reports();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
